[rtl/cwsu_pkg.sv]
// Shared types and constants for the coincidence window search unit.
package cwsu_pkg;

    // Fixed field widths of the transfer payloads and the configuration port.
    localparam int STAMP_W = 48;
    localparam int INDEX_W = 10;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 1;

    // Default exclusive window end: 10 us expressed in detector ticks.
    localparam logic signed [CFG_W-1:0] WINDOW_HIGH_RESET = 32'sd409600;
    localparam logic signed [CFG_W-1:0] WINDOW_LOW_RESET  = 32'sd0;

    // Request kinds on the input channel.
    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_type_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LOW  = 1'b0,
        REG_WINDOW_HIGH = 1'b1
    } cfg_reg_t;

    // Input item.
    typedef struct packed {
        req_type_t          req_type;
        logic [STAMP_W-1:0] stamp;
        logic               ref_valid;
        logic               restart;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] match_index;
        logic [STAMP_W-1:0] match_value;
    } out_item_t;

endpackage

[rtl/cwsu_cell.sv]
// One bisection step cell of the search chain.
module cwsu_cell #(
    parameter int CW = 11,
    parameter int AW = 10,
    parameter int SB = 48,
    parameter int KW = 50
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [CW-1:0]        in_first,
    input  logic [CW-1:0]        in_len,
    input  logic [CW-1:0]        in_mid,
    input  logic [SB-1:0]        rd_data,
    input  logic signed [KW-1:0] start_key,
    output logic                 out_valid,
    output logic [CW-1:0]        out_first,
    output logic [CW-1:0]        out_len,
    output logic [CW-1:0]        out_mid,
    output logic [AW-1:0]        rd_addr
);

    logic          valid_reg;
    logic [CW-1:0] first_reg, first_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] half;
    logic          below;

    // One step of the lower-bound bisection; the read data belongs to in_mid.
    always_comb begin
        half  = in_len >> 1;
        below = $signed({{(KW-SB){1'b0}}, rd_data}) < start_key;
        if (in_len == '0) begin
            first_next = in_first;
            len_next   = in_len;
        end else if (below) begin
            first_next = CW'(in_mid + CW'(1));
            len_next   = CW'(in_len - half - CW'(1));
        end else begin
            first_next = in_first;
            len_next   = half;
        end
        mid_next = CW'(first_next + (len_next >> 1));
        rd_addr  = in_valid ? mid_next[AW-1:0] : '0;
    end

    // The token moves on to the next cell every cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    // Step state is loaded only while the token is here, so the last cell holds it.
    always_ff @(posedge aclk) begin
        if (in_valid) begin
            first_reg <= first_next;
            len_reg   <= len_next;
            mid_reg   <= mid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_first = first_reg;
    assign out_len   = len_reg;
    assign out_mid   = mid_reg;

endmodule

[rtl/coincidence_window_search_unit.sv]
// Top level of the coincidence window search unit: timestamp table and search chain.
//
//  channel  | ports                              | role
//  ---------+------------------------------------+-------------------------------------
//  input    | s_valid, s_ready, s_payload        | table loads and window queries
//  result   | m_valid, m_ready, m_payload        | one result per query
//  config   | cfg_write, cfg_index, cfg_wdata    | window_low / window_high writes
//
// A load does not hold off the input; another item may follow in the next cycle.
// A query is launched, then steps through the bisection chain, one step per cell,
// each cell issuing one read of the single table read port, and the entry at the
// lower bound is then checked against the window. Reset clears the entry count and
// loads the window registers with their defaults; the table itself is not cleared.
// A query result waits in the output register while the next load is accepted; any
// further item, load or query, is held off until the result is in that register.
module coincidence_window_search_unit #(
    parameter int DEPTH      = 1024,
    parameter int STAMP_BITS = 48
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  cwsu_pkg::in_item_t                    s_payload,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output cwsu_pkg::out_item_t                   m_payload,
    input  logic                                  cfg_write,
    input  logic [cwsu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cwsu_pkg::CFG_W-1:0]            cfg_wdata
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int NSTEP = CW;
    localparam int SB    = STAMP_BITS;
    localparam int KW    = ((SB > cwsu_pkg::CFG_W) ? SB : cwsu_pkg::CFG_W) + 2;

    // Configuration registers.
    logic [cwsu_pkg::CFG_W-1:0] win_low_reg;
    logic [cwsu_pkg::CFG_W-1:0] win_high_reg;

    // Table state.
    logic [SB-1:0] mem [DEPTH];
    logic [SB-1:0] rd_data_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] wr_base;
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic          rd_en;

    // Query context.
    logic                 busy_reg, busy_next;
    logic                 refv_reg;
    logic signed [KW-1:0] start_reg;
    logic signed [KW-1:0] end_reg;
    logic signed [KW-1:0] start_key;
    logic signed [KW-1:0] end_key;
    logic [63:0]          stamp64;
    logic [SB-1:0]        stamp_sb;

    // Search chain links; link 0 is the launch register.
    logic [NSTEP:0] ch_valid;
    logic [CW-1:0]  ch_first [NSTEP+1];
    logic [CW-1:0]  ch_len   [NSTEP+1];
    logic [CW-1:0]  ch_mid   [NSTEP+1];
    logic [AW-1:0]  cell_addr [NSTEP];
    logic           launch_reg;
    logic [CW-1:0]  launch_len_reg;
    logic [CW-1:0]  launch_mid_reg;
    logic [CW-1:0]  init_mid;

    // Result stage.
    logic                 fin_wait_reg, fin_wait_next;
    logic                 done;
    logic                 out_free;
    logic                 result_go;
    logic                 hit;
    logic signed [KW-1:0] val_key;
    logic [63:0]          idx64;
    logic [63:0]          val64;
    logic                 m_valid_reg;
    cwsu_pkg::out_item_t  m_payload_reg;

    logic s_fire;
    logic is_load;
    logic is_query;

    assign s_ready  = !busy_reg;
    assign s_fire   = s_valid && s_ready;
    assign is_load  = s_fire && (s_payload.req_type == cwsu_pkg::REQ_LOAD);
    assign is_query = s_fire && (s_payload.req_type == cwsu_pkg::REQ_QUERY);

    // Stamp bits above STAMP_BITS are dropped.
    assign stamp64  = {{(64-cwsu_pkg::STAMP_W){1'b0}}, s_payload.stamp};
    assign stamp_sb = stamp64[SB-1:0];

    // Exact window bounds as signed values.
    assign start_key = $signed({{(KW-SB){1'b0}}, stamp_sb})
                     + $signed({{(KW-cwsu_pkg::CFG_W){win_low_reg[cwsu_pkg::CFG_W-1]}},
                                win_low_reg});
    assign end_key   = $signed({{(KW-SB){1'b0}}, stamp_sb})
                     + $signed({{(KW-cwsu_pkg::CFG_W){win_high_reg[cwsu_pkg::CFG_W-1]}},
                                win_high_reg});

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_low_reg  <= cwsu_pkg::WINDOW_LOW_RESET;
            win_high_reg <= cwsu_pkg::WINDOW_HIGH_RESET;
        end else if (cfg_write) begin
            unique case (cwsu_pkg::cfg_reg_t'(cfg_index))
                cwsu_pkg::REG_WINDOW_LOW:  win_low_reg  <= cfg_wdata;
                cwsu_pkg::REG_WINDOW_HIGH: win_high_reg <= cfg_wdata;
                default:                   win_low_reg  <= win_low_reg;
            endcase
        end
    end

    // Load append with restart and saturation at full depth.
    always_comb begin
        wr_base    = s_payload.restart ? '0 : count_reg;
        wr_en      = is_load && (wr_base < CW'(DEPTH));
        count_next = count_reg;
        if (wr_en) begin
            count_next = CW'(wr_base + CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Read address comes from the launch or from the cell holding the token.
    always_comb begin
        init_mid = count_reg >> 1;
        rd_addr  = is_query ? init_mid[AW-1:0] : '0;
        rd_en    = is_query;
        for (int k = 0; k < NSTEP; k++) begin
            rd_addr = rd_addr | cell_addr[k];
            rd_en   = rd_en | ch_valid[k];
        end
    end

    // Table memory: one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_base[AW-1:0]] <= stamp_sb;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Query launch: keys and initial bisection state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            launch_reg <= 1'b0;
        end else begin
            launch_reg <= is_query;
        end
    end

    always_ff @(posedge aclk) begin
        if (is_query) begin
            refv_reg       <= s_payload.ref_valid;
            start_reg      <= start_key;
            end_reg        <= end_key;
            launch_len_reg <= count_reg;
            launch_mid_reg <= init_mid;
        end
    end

    assign ch_valid[0] = launch_reg;
    assign ch_first[0] = '0;
    assign ch_len[0]   = launch_len_reg;
    assign ch_mid[0]   = launch_mid_reg;

    // Bisection chain, one step per cell.
    for (genvar k = 0; k < NSTEP; k++) begin : g_cell
        cwsu_cell #(
            .CW(CW),
            .AW(AW),
            .SB(SB),
            .KW(KW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (ch_valid[k]),
            .in_first  (ch_first[k]),
            .in_len    (ch_len[k]),
            .in_mid    (ch_mid[k]),
            .rd_data   (rd_data_reg),
            .start_key (start_reg),
            .out_valid (ch_valid[k+1]),
            .out_first (ch_first[k+1]),
            .out_len   (ch_len[k+1]),
            .out_mid   (ch_mid[k+1]),
            .rd_addr   (cell_addr[k])
        );
    end

    // Final check of the entry at the lower bound, read by the last cell.
    always_comb begin
        done          = ch_valid[NSTEP];
        out_free      = !m_valid_reg || m_ready;
        result_go     = (done || fin_wait_reg) && out_free;
        fin_wait_next = (done || fin_wait_reg) && !out_free;
        val_key       = $signed({{(KW-SB){1'b0}}, rd_data_reg});
        hit           = refv_reg && (ch_first[NSTEP] < count_reg)
                        && !(val_key < start_reg) && (val_key < end_reg);
        idx64         = {{(64-CW){1'b0}}, ch_first[NSTEP]};
        val64         = {{(64-SB){1'b0}}, rd_data_reg};
        busy_next     = busy_reg;
        if (is_query) begin
            busy_next = 1'b1;
        end else if (result_go) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            fin_wait_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            fin_wait_reg <= fin_wait_next;
        end
    end

    // Output register; a transfer frees it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result_go) begin
            m_payload_reg.found       <= hit;
            m_payload_reg.match_index <= hit ? idx64[cwsu_pkg::INDEX_W-1:0] : '0;
            m_payload_reg.match_value <= hit ? val64[cwsu_pkg::STAMP_W-1:0] : '0;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

[verif/window_search_checker.sv]
// Checker for the coincidence window search unit: predicts query results and compares them.
`timescale 1ns / 1ps

module window_search_checker #(
    parameter int DEPTH = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  cwsu_pkg::in_item_t             s_payload,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  cwsu_pkg::out_item_t            m_payload,
    input  logic                           cfg_write,
    input  logic [cwsu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cwsu_pkg::CFG_W-1:0]     cfg_wdata,
    output int                             mismatch_total,
    output int                             queries_open
);
    import cwsu_pkg::*;

    // Shadow copy of the hit table and window registers.
    logic [STAMP_W-1:0]      hit_table [DEPTH];
    int unsigned             hit_count;
    logic signed [CFG_W-1:0] win_low;
    logic signed [CFG_W-1:0] win_high;

    // Results still owed by the block, oldest first.
    out_item_t               pending_results [$];
    int                      errors = 0;

    // Stamps are unsigned, so they always fit a non-negative tick count.
    function automatic longint as_ticks(input logic [STAMP_W-1:0] stamp);
        return longint'({{(64 - STAMP_W){1'b0}}, stamp});
    endfunction

    // Lower-bound bisection: first position whose entry is not below the key.
    function automatic int unsigned first_not_below(input longint key);
        int unsigned first;
        int unsigned len;
        int unsigned half;
        int unsigned mid;
        first = 0;
        len   = hit_count;
        while (len > 0) begin
            half = len / 2;
            mid  = first + half;
            if (as_ticks(hit_table[mid]) < key) begin
                first = mid + 1;
                len   = len - half - 1;
            end else begin
                len = half;
            end
        end
        return first;
    endfunction

    // Result of a window query against the current table and window.
    function automatic out_item_t window_lookup(input in_item_t query);
        out_item_t   res;
        longint      t0;
        longint      start_t;
        longint      end_t;
        longint      hit;
        int unsigned pos;
        res = '0;
        if (query.ref_valid) begin
            t0      = as_ticks(query.stamp);
            start_t = t0 + longint'(win_low);
            end_t   = t0 + longint'(win_high);
            pos     = first_not_below(start_t);
            if (pos < hit_count) begin
                hit = as_ticks(hit_table[pos]);
                if (hit >= start_t && hit < end_t) begin
                    res.found       = 1'b1;
                    res.match_index = pos[INDEX_W-1:0];
                    res.match_value = hit_table[pos];
                end
            end
        end
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [STAMP_W-1:0] want,
                                 input logic [STAMP_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        end
    endtask

    // Track configuration, loads and queries, and check each result transfer.
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            hit_count = 0;
            win_low   = WINDOW_LOW_RESET;
            win_high  = WINDOW_HIGH_RESET;
            pending_results.delete();
        end else begin
            if (cfg_write) begin
                case (cfg_reg_t'(cfg_index))
                    REG_WINDOW_LOW: begin
                        win_low = cfg_wdata;
                    end
                    REG_WINDOW_HIGH: begin
                        win_high = cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: result expected none actual %0h", $time, m_payload);
                end else begin
                    want = pending_results.pop_front();
                    compare_field("found", STAMP_W'(want.found), STAMP_W'(m_payload.found));
                    compare_field("match_index", STAMP_W'(want.match_index),
                                  STAMP_W'(m_payload.match_index));
                    compare_field("match_value", want.match_value, m_payload.match_value);
                end
            end
            if (s_valid && s_ready) begin
                if (s_payload.req_type == REQ_QUERY) begin
                    pending_results.insert(pending_results.size(), window_lookup(s_payload));
                end else begin
                    // A restart empties the table; a load into a full table is dropped.
                    if (s_payload.restart) begin
                        hit_count = 0;
                    end
                    if (hit_count < DEPTH) begin
                        hit_table[hit_count] = s_payload.stamp;
                        hit_count++;
                    end
                end
            end
        end
        queries_open   <= pending_results.size();
        mismatch_total <= errors;
    end

endmodule

[verif/tb_top.sv]
// Testbench top for the coincidence window search unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import cwsu_pkg::*;

    localparam int     DEPTH           = 1024;
    localparam int     CLK_HALF        = 6;
    localparam int     RUN_LIMIT       = 600000;
    localparam int     SETTLE_CYCLES   = 16;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     PHASE_ITEMS     = 30;
    localparam longint STAMP_MAX       = (longint'(1) << STAMP_W) - 1;
    localparam logic signed [CFG_W-1:0] WIN_MIN = 32'sh8000_0000;
    localparam logic signed [CFG_W-1:0] WIN_MAX = 32'sh7FFF_FFFF;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_payload = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_payload;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    int          hold_asks    = 0;
    int          hold_served  = 0;
    int          hold_left    = 0;
    int          items_sent   = 0;
    int unsigned cycle_count  = 0;
    int          mismatch_total;
    int          queries_open;

    // Stamps believed to be in the table, used to aim query times at real hits.
    logic [STAMP_W-1:0] loaded_stamps [$];

    coincidence_window_search_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    window_search_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload      (m_payload),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_total (mismatch_total),
        .queries_open   (queries_open)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random back-pressure, plus a long hold-off when one is asked for.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asks) begin
            hold_served <= hold_asks;
            hold_left   <= HOLD_OFF_CYCLES;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    function automatic logic [STAMP_W-1:0] any_stamp();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[STAMP_W-1:0];
    endfunction

    // Query time close to a stored hit, sometimes exactly on it, sometimes anywhere.
    function automatic logic [STAMP_W-1:0] near_hit();
        longint t;
        if (loaded_stamps.size() == 0 || $urandom_range(0, 9) == 0) begin
            return any_stamp();
        end
        t = longint'({16'd0, loaded_stamps[$urandom_range(0, loaded_stamps.size() - 1)]});
        if ($urandom_range(0, 3) != 0) begin
            t = t + longint'($urandom_range(0, 8000)) - 4000;
        end
        if (t < 0) begin
            t = 0;
        end else if (t > STAMP_MAX) begin
            t = STAMP_MAX;
        end
        return t[STAMP_W-1:0];
    endfunction

    // Offer one item and hold it until the transfer, after an optional idle gap.
    task automatic send_item(input in_item_t item);
        int gap;
        if ($urandom_range(0, 99) < src_idle_pct) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic load_stamp(input logic [STAMP_W-1:0] stamp, input logic restart);
        in_item_t item;
        item.req_type  = REQ_LOAD;
        item.stamp     = stamp;
        item.ref_valid = 1'($urandom_range(0, 1));
        item.restart   = restart;
        if (restart) begin
            loaded_stamps.delete();
        end
        if (loaded_stamps.size() < DEPTH) begin
            loaded_stamps.insert(loaded_stamps.size(), stamp);
        end
        send_item(item);
    endtask

    task automatic ask_window(input logic [STAMP_W-1:0] t0, input logic ref_valid);
        in_item_t item;
        item.req_type  = REQ_QUERY;
        item.stamp     = t0;
        item.ref_valid = ref_valid;
        item.restart   = 1'($urandom_range(0, 1));
        send_item(item);
    endtask

    // Let all queries drain, then rewrite both window registers.
    task automatic settle_window(input logic signed [CFG_W-1:0] lo,
                                 input logic signed [CFG_W-1:0] hi);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (queries_open != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_write <= 1'b1;
        cfg_index <= REG_WINDOW_LOW;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= REG_WINDOW_HIGH;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_write <= 1'b0;
    endtask

    // One random burst: mostly a fresh sorted table followed by queries into it.
    task automatic run_burst(input bit fill_table);
        int                 kind;
        int                 n_loads;
        int                 n_queries;
        logic [STAMP_W-1:0] at;
        kind      = fill_table ? 0 : $urandom_range(0, 9);
        n_loads   = fill_table ? DEPTH + 4 : $urandom_range(1, 40);
        n_queries = fill_table ? 40 : $urandom_range(1, 8);
        if (kind <= 6) begin
            case ($urandom_range(0, 9))
                0: at = STAMP_W'(STAMP_MAX - longint'($urandom_range(0, 20000)));
                1: at = STAMP_W'($urandom_range(0, 5000));
                default: at = any_stamp();
            endcase
            load_stamp(at, 1'b1);
            repeat (n_loads - 1) begin
                at = at + STAMP_W'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1200));
                load_stamp(at, 1'b0);
            end
            repeat (n_queries) ask_window(near_hit(), $urandom_range(0, 15) != 0);
        end else if (kind == 7) begin
            // Append to whatever is there; may overflow a full table.
            at = (loaded_stamps.size() > 0) ? loaded_stamps[$] : any_stamp();
            repeat ($urandom_range(1, 6)) begin
                at = at + STAMP_W'($urandom_range(0, 1500));
                load_stamp(at, 1'b0);
            end
            repeat (n_queries) ask_window(near_hit(), 1'b1);
        end else if (kind == 8) begin
            // Noise: loose items of either kind with arbitrary fields.
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 1) == 0) begin
                    load_stamp(any_stamp(), 1'($urandom_range(0, 1)));
                end else begin
                    ask_window(any_stamp(), 1'($urandom_range(0, 1)));
                end
            end
        end else begin
            // Unsorted table in a narrow range.
            at = any_stamp();
            load_stamp(at, 1'b1);
            repeat (n_loads - 1) load_stamp(at + STAMP_W'($urandom_range(0, 5000)), 1'b0);
            repeat (n_queries) ask_window(near_hit(), 1'b1);
        end
    endtask

    initial begin
        int                      goal;
        logic signed [CFG_W-1:0] lo;
        logic signed [CFG_W-1:0] hi;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, field extremes and the invalid reference, at reset window.
        ask_window('0, 1'b1);
        load_stamp('0, 1'b0);
        load_stamp(48'd100, 1'b0);
        load_stamp(48'd409700, 1'b0);
        load_stamp(STAMP_MAX[STAMP_W-1:0], 1'b0);
        ask_window('0, 1'b1);
        ask_window(48'd1, 1'b1);
        ask_window('0, 1'b0);
        ask_window(48'd100, 1'b1);
        ask_window(48'd101, 1'b1);
        ask_window(STAMP_MAX[STAMP_W-1:0], 1'b1);
        ask_window(STAMP_MAX[STAMP_W-1:0] - 48'd409599, 1'b1);
        // Restart into an unsorted table.
        load_stamp(48'd500, 1'b1);
        load_stamp(48'd300, 1'b0);
        ask_window('0, 1'b1);
        ask_window(48'd400, 1'b1);
        // Empty window, then the widest window with a start below zero.
        settle_window(32'sd5, 32'sd5);
        ask_window(48'd495, 1'b1);
        settle_window(WIN_MIN, WIN_MAX);
        ask_window('0, 1'b1);
        ask_window(STAMP_MAX[STAMP_W-1:0], 1'b1);

        // Random phases: window setting and idle pattern change per phase.
        for (int ph = 0; ph < 6; ph++) begin
            src_idle_pct <= (ph < 2) ? 18 : (ph < 4) ? 66 : 0;
            snk_idle_pct <= (ph < 2) ? 66 : (ph < 4) ? 18 : 0;
            case (ph)
                0: begin lo = -32'sd2000; hi = 32'sd3000; end
                1: begin lo = 32'sd300;   hi = 32'sd700;  end
                2: begin lo = WIN_MIN;    hi = WIN_MAX;   end
                3: begin lo = WIN_MAX;    hi = WIN_MIN;   end
                4: begin lo = 32'sd0;     hi = 32'sd1;    end
                default: begin
                    lo = -$signed($urandom_range(0, 3000));
                    hi = $urandom_range(0, 3000);
                end
            endcase
            settle_window(lo, hi);
            if (ph == 4) begin
                hold_asks <= hold_asks + 1;
            end
            goal = items_sent + PHASE_ITEMS;
            if (ph == 5) begin
                run_burst(1'b1);
            end
            while (items_sent < goal) run_burst(1'b0);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (queries_open != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_total == 0 && queries_open == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
rtl/cwsu_pkg.sv
rtl/cwsu_cell.sv
rtl/coincidence_window_search_unit.sv
verif/window_search_checker.sv
verif/tb_top.sv
